// ----- rtl/core/e2h_pkg.sv -----
// ----------------------------------------------------------------------------
// e2h_pkg
// Shared widths, CORDIC constants and the arctangent step table for the
// equatorial to horizontal coordinate transform.
// ----------------------------------------------------------------------------
`default_nettype none

package e2h_pkg;

   localparam int ANGLE_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 30;
   localparam int PORT_W            = 32;
   localparam int Q_FRAC            = 30;
   // Q30 sine/cosine with headroom for CORDIC overshoot and sign
   localparam int ROT_W             = 34;
   // vectoring carries up to about 2.4 in Q30 after the CORDIC gain
   localparam int VEC_W             = 36;
   localparam int K_W               = 31;
   localparam logic signed [K_W-1:0] CORDIC_K = 31'sd652032874;
   localparam int ATAN_ENTRIES      = 32;

   localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   // atan(2^-i) scaled to a binary angle of w bits; zero past the table
   function automatic logic [63:0] atan_step(input int i, input int w);
      logic [63:0] t;
      t = '0;
      if (i < ATAN_ENTRIES) begin
         t = {32'd0, ATAN_TABLE[i]};
         if (w >= 32) t = t << (w - 32);
         else t = t >> (32 - w);
      end
      return t;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/e2h_rot_cell.sv -----
// ----------------------------------------------------------------------------
// e2h_rot_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module e2h_rot_cell
   import e2h_pkg::*;
#(
   parameter int AW    = ANGLE_WIDTH_DEF,
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [ROT_W-1:0] x_i,
   input  logic signed [ROT_W-1:0] y_i,
   input  logic signed [AW-1:0]    z_i,
   input  logic                    flip_i,
   output logic signed [ROT_W-1:0] x_o,
   output logic signed [ROT_W-1:0] y_o,
   output logic signed [AW-1:0]    z_o,
   output logic                    flip_o
);

   localparam logic signed [AW-1:0] STEP = signed'(AW'(atan_step(STAGE, AW)));

   logic signed [ROT_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [AW-1:0]    z_ff, z_in;
   logic                    flip_ff;

   always_comb begin
      dx = y_i >>> STAGE;
      dy = x_i >>> STAGE;
      if (z_i >= 0) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - STEP;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         flip_ff <= flip_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign flip_o = flip_ff;

endmodule

`default_nettype wire

// ----- rtl/core/e2h_sincos.sv -----
// ----------------------------------------------------------------------------
// e2h_sincos
// Quadrant fold, a chain of rotation cells and the sign restore: sine and
// cosine of a binary angle in Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module e2h_sincos
   import e2h_pkg::*;
#(
   parameter int AW     = ANGLE_WIDTH_DEF,
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [AW-1:0]           angle,
   output logic signed [ROT_W-1:0] sin_o,
   output logic signed [ROT_W-1:0] cos_o
);

   logic signed [ROT_W-1:0] x_c [STAGES+1];
   logic signed [ROT_W-1:0] y_c [STAGES+1];
   logic signed [AW-1:0]    z_c [STAGES+1];
   logic                    f_c [STAGES+1];

   logic          flip;
   logic [AW-1:0] z_fold;
   logic signed [ROT_W-1:0] x0_ff, y0_ff;
   logic signed [AW-1:0]    z0_ff;
   logic                    f0_ff;
   logic signed [ROT_W-1:0] sin_ff, sin_in, cos_ff, cos_in;

   // second or third quadrant: move by a half turn, negate at the end
   always_comb begin
      flip   = angle[AW-1] ^ angle[AW-2];
      z_fold = flip ? {~angle[AW-1], angle[AW-2:0]} : angle;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff <= ROT_W'(CORDIC_K);
         y0_ff <= '0;
         z0_ff <= signed'(z_fold);
         f0_ff <= flip;
      end
   end

   assign x_c[0] = x0_ff;
   assign y_c[0] = y0_ff;
   assign z_c[0] = z0_ff;
   assign f_c[0] = f0_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      e2h_rot_cell #(.AW(AW), .STAGE(i)) u_cell (
         .clock  (clock),
         .en     (en),
         .x_i    (x_c[i]),
         .y_i    (y_c[i]),
         .z_i    (z_c[i]),
         .flip_i (f_c[i]),
         .x_o    (x_c[i+1]),
         .y_o    (y_c[i+1]),
         .z_o    (z_c[i+1]),
         .flip_o (f_c[i+1])
      );
   end

   always_comb begin
      sin_in = f_c[STAGES] ? -y_c[STAGES] : y_c[STAGES];
      cos_in = f_c[STAGES] ? -x_c[STAGES] : x_c[STAGES];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_o = sin_ff;
   assign cos_o = cos_ff;

endmodule

`default_nettype wire

// ----- rtl/core/e2h_vec_cell.sv -----
// ----------------------------------------------------------------------------
// e2h_vec_cell
// One vectoring-mode CORDIC micro-rotation with a sideband field, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module e2h_vec_cell
   import e2h_pkg::*;
#(
   parameter int AW    = ANGLE_WIDTH_DEF,
   parameter int AUX_W = VEC_W,
   parameter int STAGE = 0
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VEC_W-1:0] x_i,
   input  logic signed [VEC_W-1:0] y_i,
   input  logic [AW-1:0]           z_i,
   input  logic                    zero_i,
   input  logic [AUX_W-1:0]        aux_i,
   output logic signed [VEC_W-1:0] x_o,
   output logic signed [VEC_W-1:0] y_o,
   output logic [AW-1:0]           z_o,
   output logic                    zero_o,
   output logic [AUX_W-1:0]        aux_o
);

   localparam logic [AW-1:0] STEP = AW'(atan_step(STAGE, AW));

   logic signed [VEC_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic [AW-1:0]           z_ff, z_in;
   logic                    zero_ff;
   logic [AUX_W-1:0]        aux_ff;

   always_comb begin
      dx = y_i >>> STAGE;
      dy = x_i >>> STAGE;
      if (y_i < 0) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - STEP;
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         zero_ff <= zero_i;
         aux_ff  <= aux_i;
      end
   end

   assign x_o    = x_ff;
   assign y_o    = y_ff;
   assign z_o    = z_ff;
   assign zero_o = zero_ff;
   assign aux_o  = aux_ff;

endmodule

`default_nettype wire

// ----- rtl/core/e2h_atan2.sv -----
// ----------------------------------------------------------------------------
// e2h_atan2
// Half-plane fold, a chain of vectoring cells and the zero-vector override:
// atan2(y, x) as a binary angle plus the gained magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module e2h_atan2
   import e2h_pkg::*;
#(
   parameter int AW     = ANGLE_WIDTH_DEF,
   parameter int STAGES = CORDIC_STAGES_DEF,
   parameter int AUX_W  = VEC_W
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VEC_W-1:0] y_i,
   input  logic signed [VEC_W-1:0] x_i,
   input  logic [AUX_W-1:0]        aux_i,
   output logic [AW-1:0]           angle_o,
   output logic signed [VEC_W-1:0] mag_o,
   output logic [AUX_W-1:0]        aux_o
);

   logic signed [VEC_W-1:0] x_c [STAGES+1];
   logic signed [VEC_W-1:0] y_c [STAGES+1];
   logic [AW-1:0]           z_c [STAGES+1];
   logic                    n_c [STAGES+1];
   logic [AUX_W-1:0]        a_c [STAGES+1];

   logic signed [VEC_W-1:0] x0_ff, y0_ff;
   logic [AW-1:0]           z0_ff;
   logic                    n0_ff;
   logic [AUX_W-1:0]        a0_ff;

   logic [AW-1:0]           ang_ff, ang_in;
   logic signed [VEC_W-1:0] mag_ff;
   logic [AUX_W-1:0]        aux_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         // left half-plane: pre-rotate by a half turn
         if (x_i < 0) begin
            x0_ff <= -x_i;
            y0_ff <= -y_i;
            z0_ff <= {1'b1, {(AW-1){1'b0}}};
         end else begin
            x0_ff <= x_i;
            y0_ff <= y_i;
            z0_ff <= '0;
         end
         n0_ff <= (x_i == 0) && (y_i == 0);
         a0_ff <= aux_i;
      end
   end

   assign x_c[0] = x0_ff;
   assign y_c[0] = y0_ff;
   assign z_c[0] = z0_ff;
   assign n_c[0] = n0_ff;
   assign a_c[0] = a0_ff;

   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      e2h_vec_cell #(.AW(AW), .AUX_W(AUX_W), .STAGE(i)) u_cell (
         .clock  (clock),
         .en     (en),
         .x_i    (x_c[i]),
         .y_i    (y_c[i]),
         .z_i    (z_c[i]),
         .zero_i (n_c[i]),
         .aux_i  (a_c[i]),
         .x_o    (x_c[i+1]),
         .y_o    (y_c[i+1]),
         .z_o    (z_c[i+1]),
         .zero_o (n_c[i+1]),
         .aux_o  (a_c[i+1])
      );
   end

   assign ang_in = n_c[STAGES] ? '0 : z_c[STAGES];

   always_ff @(posedge clock) begin
      if (en) begin
         ang_ff <= ang_in;
         mag_ff <= x_c[STAGES];
         aux_ff <= a_c[STAGES];
      end
   end

   assign angle_o = ang_ff;
   assign mag_o   = mag_ff;
   assign aux_o   = aux_ff;

endmodule

`default_nettype wire

// ----- rtl/core/equatorial_to_horizontal.sv -----
// ----------------------------------------------------------------------------
// equatorial_to_horizontal
// Hour angle and declination to azimuth (westward from south) and altitude,
// observer latitude held in a register. CORDIC cell chains throughout.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| req_hour_angle, req_declination
//  rsp     | out       | rsp_valid/rsp_stall| rsp_azimuth, rsp_altitude
//  csr     | in        | csr_valid/csr_ready| csr_observer_latitude
//
//  One item per cycle unless a stalled result freezes the pipe; stages are
//  sine/cosine chain, three vector stages, two arctangent chains, scale.
//  Reset (synchronous) empties the pipeline and clears the latitude to zero.
//  A stalled result freezes the pipe only while its last stage holds an item;
//  bubbles keep draining, so inputs are still taken behind a waiting result.
// ----------------------------------------------------------------------------
`default_nettype none

module equatorial_to_horizontal
   import e2h_pkg::*;
#(
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [PORT_W-1:0] req_hour_angle,
   input  logic signed [PORT_W-1:0] req_declination,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [PORT_W-1:0] rsp_azimuth,
   output logic signed [PORT_W-1:0] rsp_altitude,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic signed [PORT_W-1:0] csr_observer_latitude
);

   localparam int AW    = ANGLE_WIDTH;
   localparam int LAT   = 3 * CORDIC_STAGES + 10;
   localparam int EXT_W = (AW > PORT_W) ? AW : PORT_W;
   localparam int PW    = 2 * ROT_W;
   localparam logic signed [AW-1:0] QTR = signed'(AW'(1) << (AW - 2));

   logic                    en;
   logic [LAT-1:0]          valid_ff, valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PORT_W-1:0]       rsp_az_ff, rsp_az_in, rsp_alt_ff, rsp_alt_in;
   logic [PORT_W-1:0]       lat_ff;

   logic [EXT_W-1:0]        ha_ext, de_ext, la_ext, az_ext, alt_ext;
   logic signed [ROT_W-1:0] sh, ch, sd, cd, sp, cp;

   logic signed [PW-1:0]    m0, m1, m2, m3, m4, m5, m6;
   logic signed [ROT_W-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, cd_ff, ch_ff;
   logic signed [ROT_W-1:0] r0_ff, r1_ff, r2_ff, r3_ff, r4_ff;
   logic signed [VEC_W-1:0] v0_ff, v1_ff, v2_ff;

   logic [AW-1:0]           az1, az2, alt_raw;
   logic signed [VEC_W-1:0] mag1, mag2, v2_d;
   logic [VEC_W-1:0]        v2_aux;
   logic signed [VEC_W+K_W-1:0] sc;
   logic signed [VEC_W-1:0] r_ff;
   logic signed [VEC_W-1:0] v2_d_ff;
   logic [AW-1:0]           az_d_ff;
   logic signed [AW-1:0]    alt_sat;

   // ---------------- handshake ----------------
   assign en        = !(rsp_valid_ff && rsp_stall && valid_ff[LAT-1]);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) lat_ff <= '0;
      else if (csr_valid) lat_ff <= csr_observer_latitude;
   end

   assign valid_in = {valid_ff[LAT-2:0], req_valid && !req_stall};

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (en) valid_ff <= valid_in;
   end

   // ---------------- sine and cosine ----------------
   assign ha_ext = EXT_W'($unsigned(req_hour_angle));
   assign de_ext = EXT_W'($unsigned(req_declination));
   assign la_ext = EXT_W'(lat_ff);

   e2h_sincos #(.AW(AW), .STAGES(CORDIC_STAGES)) u_sc_ha (
      .clock(clock), .en(en), .angle(ha_ext[AW-1:0]), .sin_o(sh), .cos_o(ch));
   e2h_sincos #(.AW(AW), .STAGES(CORDIC_STAGES)) u_sc_de (
      .clock(clock), .en(en), .angle(de_ext[AW-1:0]), .sin_o(sd), .cos_o(cd));
   e2h_sincos #(.AW(AW), .STAGES(CORDIC_STAGES)) u_sc_la (
      .clock(clock), .en(en), .angle(la_ext[AW-1:0]), .sin_o(sp), .cos_o(cp));

   // ---------------- direction vector ----------------
   assign m0 = PW'(cd) * PW'(sh);
   assign m1 = PW'(ch) * PW'(sp);
   assign m2 = PW'(sd) * PW'(cp);
   assign m3 = PW'(sp) * PW'(sd);
   assign m4 = PW'(cp) * PW'(cd);
   assign m5 = PW'(p1_ff) * PW'(cd_ff);
   assign m6 = PW'(p4_ff) * PW'(ch_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff <= ROT_W'(m0 >>> Q_FRAC);
         p1_ff <= ROT_W'(m1 >>> Q_FRAC);
         p2_ff <= ROT_W'(m2 >>> Q_FRAC);
         p3_ff <= ROT_W'(m3 >>> Q_FRAC);
         p4_ff <= ROT_W'(m4 >>> Q_FRAC);
         cd_ff <= cd;
         ch_ff <= ch;
         r0_ff <= p0_ff;
         r1_ff <= ROT_W'(m5 >>> Q_FRAC);
         r2_ff <= p2_ff;
         r3_ff <= p3_ff;
         r4_ff <= ROT_W'(m6 >>> Q_FRAC);
         v0_ff <= VEC_W'(r0_ff);
         v1_ff <= VEC_W'(r1_ff) - VEC_W'(r2_ff);
         v2_ff <= VEC_W'(r3_ff) + VEC_W'(r4_ff);
      end
   end

   // ---------------- azimuth, magnitude, altitude ----------------
   e2h_atan2 #(.AW(AW), .STAGES(CORDIC_STAGES), .AUX_W(VEC_W)) u_at_az (
      .clock(clock), .en(en), .y_i(v0_ff), .x_i(v1_ff), .aux_i(v2_ff),
      .angle_o(az1), .mag_o(mag1), .aux_o(v2_aux));

   assign v2_d = signed'(v2_aux);
   assign sc   = (VEC_W+K_W)'(mag1) * (VEC_W+K_W)'(CORDIC_K);

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= VEC_W'(sc >>> Q_FRAC);
         az_d_ff <= az1;
      end
   end

   // v2 rides one stage behind in r_ff's slot; keep it aligned
   always_ff @(posedge clock) begin
      if (en) v2_d_ff <= v2_d;
   end

   e2h_atan2 #(.AW(AW), .STAGES(CORDIC_STAGES), .AUX_W(AW)) u_at_alt (
      .clock(clock), .en(en), .y_i(v2_d_ff), .x_i(r_ff), .aux_i(az_d_ff),
      .angle_o(alt_raw), .mag_o(mag2), .aux_o(az2));

   always_comb begin
      alt_sat = signed'(alt_raw);
      if (alt_sat > QTR) alt_sat = QTR;
      if (alt_sat < -QTR) alt_sat = -QTR;
      az_ext     = EXT_W'(az2);
      alt_ext    = EXT_W'($unsigned(alt_sat));
      rsp_az_in  = az_ext[PORT_W-1:0];
      rsp_alt_in = alt_ext[PORT_W-1:0];
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || !rsp_stall) rsp_valid_in = valid_ff[LAT-1];
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_az_ff  <= rsp_az_in;
         rsp_alt_ff <= rsp_alt_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_azimuth  = signed'(rsp_az_ff);
   assign rsp_altitude = signed'(rsp_alt_ff);

   // ---------------- assertions ----------------
   // magnitude of the second vector is not needed beyond the check below
   a_mag_nonneg: assert property (@(posedge clock) disable iff (reset)
      valid_ff[LAT-1] |-> mag2 >= 0)
      else $error("altitude vector magnitude negative");

   a_freeze_full: assert property (@(posedge clock) disable iff (reset)
      !en |-> rsp_valid_ff && valid_ff[LAT-1])
      else $error("pipeline frozen without a waiting result");

   a_freeze_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> valid_ff[LAT-1] && rsp_valid_ff)
      else $error("frozen last stage lost its item");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
